@@ rtl/tach_pkg.sv @@
// Shared constants, types and helpers of the pulse period tachometer.
package tach_pkg;

    localparam int TIME_WIDTH_DEF = 32;

    localparam int DIV_W      = 64;
    localparam int DIV_CNT_W  = $clog2(DIV_W + 1);
    localparam int MUL_B_W    = 17;
    localparam int MUL_CNT_W  = $clog2(MUL_B_W + 1);

    localparam int OUT_W      = 32;
    localparam int PPR_W      = 8;
    localparam int TMO_W      = 24;
    localparam int HYS_W      = 16;
    localparam int BOUND_W    = 24;
    localparam int CNT_W      = 4;
    localparam int CFG_W      = 24;
    localparam int CFG_IDX_W  = 3;

    localparam int FREQ_BITS  = 34;
    localparam int ROT_W      = 35;
    localparam int ROT5_W     = 38;
    localparam int WHL_W      = 34;
    localparam int PICK_BITS  = 48;
    localparam int X_W        = 44;
    localparam int SPEED_SHIFT = 24;

    localparam logic [FREQ_BITS-1:0] FREQ_NUMERATOR = 34'd10000000000;
    localparam logic [MUL_B_W-1:0]   SPEED_FACTOR   = 17'd114199;
    localparam logic [DIV_W-1:0]     X_CAP          = 64'h0000_07FF_FFFF_FFFF;
    localparam logic [DIV_W-1:0]     RPM_DIVISOR    = 64'd100;
    localparam logic [DIV_W-1:0]     WHEEL_DIVISOR  = 64'd13;
    localparam int                   INIT_INTERVAL  = 101000;

    localparam logic [PPR_W-1:0]   PPR_RST   = 8'd20;
    localparam logic [TMO_W-1:0]   TMO_RST   = 24'd100000;
    localparam logic [HYS_W-1:0]   HYS_RST   = 16'd2000;
    localparam logic [BOUND_W-1:0] SLOW_RST  = 24'd40000;
    localparam logic [BOUND_W-1:0] FAST_RST  = 24'd5000;
    localparam logic [CNT_W-1:0]   MAXC_RST  = 4'd10;

    localparam logic [CFG_IDX_W-1:0] CFG_PPR  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TMO  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HYS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAXC = 3'd5;

    localparam logic OP_EDGE = 1'b0;
    localparam logic OP_POLL = 1'b1;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] len;
    } div_req_t;

    function automatic logic [OUT_W-1:0] sat32(input logic [DIV_W-1:0] v);
        logic [OUT_W-1:0] r;
        r = (v[DIV_W-1:OUT_W] != '0) ? '1 : v[OUT_W-1:0];
        return r;
    endfunction

endpackage

@@ rtl/tach_div.sv @@
// Restoring divider taking one quotient bit per cycle from a left-aligned dividend.
module tach_div
    import tach_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  div_req_t         req,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DIV_W-1:0] divisor,
    output unit_stat_t       stat,
    output logic [DIV_W-1:0] quotient
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0]     dvd_reg, dvd_next;
    logic [DIV_W-1:0]     dsr_reg, dsr_next;
    logic [DIV_W-1:0]     rem_reg, rem_next;
    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [DIV_W:0]       trial;
    logic [DIV_W:0]       diff;
    logic                 ge;

    assign trial = {rem_reg, dvd_reg[DIV_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign ge    = (trial >= {1'b0, dsr_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = req.len;
            dvd_next  = dividend;
            dsr_next  = divisor;
            rem_next  = '0;
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[DIV_W-2:0], 1'b0};
            rem_next = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
            quo_next = {quo_reg[DIV_W-2:0], ge};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

@@ rtl/tach_mul.sv @@
// Shift-and-add multiplier consuming one multiplier bit per cycle.
module tach_mul
    import tach_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [DIV_W-1:0]   mcand,
    input  logic [MUL_B_W-1:0] mplier,
    output unit_stat_t         stat,
    output logic [DIV_W-1:0]   product
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [MUL_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0]     mcand_reg, mcand_next;
    logic [MUL_B_W-1:0]   mplier_reg, mplier_next;
    logic [DIV_W-1:0]     acc_reg, acc_next;

    always_comb
    begin
        busy_next   = busy_reg;
        done_next   = 1'b0;
        cnt_next    = cnt_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        acc_next    = acc_reg;
        if (start)
        begin
            busy_next   = 1'b1;
            cnt_next    = MUL_CNT_W'(MUL_B_W);
            mcand_next  = mcand;
            mplier_next = mplier;
            acc_next    = '0;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
            begin
                acc_next = acc_reg + mcand_reg;
            end
            mcand_next  = {mcand_reg[DIV_W-2:0], 1'b0};
            mplier_next = {1'b0, mplier_reg[MUL_B_W-1:1]};
            cnt_next    = cnt_reg - 1'b1;
            if (cnt_reg == MUL_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        acc_reg    <= acc_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign product   = acc_reg;

endmodule

@@ rtl/pulse_period_tachometer.sv @@
// Top level of the pulse period tachometer: sequencer, state and result register.
//
// Input channel (in_valid/in_ready) carries one request: operation 0 is a pulse
// edge, operation 1 a poll, each with a wrapping microsecond stamp time_us.
// Output channel (out_valid/out_ready) returns one result per poll; edges give none.
// Configuration is written via cfg_we/cfg_index/cfg_data, by the user only while idle.
// An edge that does not close an averaging group finishes in the accepting cycle.
// An edge closing a group runs one TIME_WIDTH-bit division and, if the count map
// calls for it, a multiply and a 48-bit division before the next request is taken.
// A poll runs five divisions of 34 to 38 bits and one multiply, all on
// one shared bit-serial divider and multiplier, and its result loads once the
// output register is free.
// One request is in work at a time; in_ready is high only while the sequencer idles.
// A finished poll waits in the output register; edges are still taken meanwhile,
// and a further poll holds its result until the register frees.
// Reset restores the configuration defaults, presets the timing state and empties
// the output register.
module pulse_period_tachometer
    import tach_pkg::*;
#(
    parameter int TIME_WIDTH = TIME_WIDTH_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 operation,
    input  logic [31:0]          time_us,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [OUT_W-1:0]     pulse_freq_x1e4,
    output logic [OUT_W-1:0]     rotor_rpm_x10,
    output logic [OUT_W-1:0]     wheel_rpm_x10,
    output logic [OUT_W-1:0]     wheel_speed,
    output logic [OUT_W-1:0]     last_interval_us,
    output logic                 stopped,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    localparam int TW = TIME_WIDTH;

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_AVG  = 4'd1;
    localparam logic [3:0] ST_PMUL = 4'd2;
    localparam logic [3:0] ST_PDIV = 4'd3;
    localparam logic [3:0] ST_FREQ = 4'd4;
    localparam logic [3:0] ST_ROT  = 4'd5;
    localparam logic [3:0] ST_RPM  = 4'd6;
    localparam logic [3:0] ST_WHL  = 4'd7;
    localparam logic [3:0] ST_WRPM = 4'd8;
    localparam logic [3:0] ST_SPD  = 4'd9;
    localparam logic [3:0] ST_OUT  = 4'd10;

    logic [3:0]         state_reg, state_next;
    logic               go_reg, go_next;
    logic               out_valid_reg, out_valid_next;

    logic [PPR_W-1:0]   ppr_reg;
    logic [TMO_W-1:0]   tmo_reg;
    logic [HYS_W-1:0]   hys_reg;
    logic [BOUND_W-1:0] slow_reg;
    logic [BOUND_W-1:0] fast_reg;
    logic [CNT_W-1:0]   maxc_reg;

    logic [TW-1:0]      last_reg, last_next;
    logic [TW-1:0]      piv_reg, piv_next;
    logic [TW-1:0]      avg_reg, avg_next;
    logic [TW-1:0]      sum_reg, sum_next;
    logic [CNT_W-1:0]   ac_reg, ac_next;
    logic [CNT_W-1:0]   pig_reg, pig_next;
    logic               hon_reg, hon_next;

    logic               stop_reg, stop_next;
    logic [OUT_W-1:0]   liv_reg, liv_next;
    logic [OUT_W-1:0]   freq_reg, freq_next;
    logic [ROT_W-1:0]   rotor_reg, rotor_next;
    logic [OUT_W-1:0]   rpm_reg, rpm_next;
    logic [WHL_W-1:0]   wheel_reg, wheel_next;
    logic [OUT_W-1:0]   wrpm_reg, wrpm_next;

    logic [OUT_W-1:0]   o_freq_reg, o_rotor_reg, o_wheel_reg, o_speed_reg, o_liv_reg;
    logic               o_stop_reg;
    logic               out_load;

    logic [DIV_W-1:0]   time_ext;
    logic [TW-1:0]      now;
    logic [TW-1:0]      iv;
    logic [TW:0]        sum_add;
    logic [TW-1:0]      sum_sat;
    logic [TW-1:0]      idle;
    logic [TMO_W-1:0]   lower;
    logic [TMO_W-1:0]   thr;
    logic               stop_now;

    logic [CNT_W-1:0]   top;
    logic [CNT_W-1:0]   top_m1;
    logic [DIV_W-1:0]   iv_wide;
    logic [X_W-1:0]     x;
    logic [X_W-1:0]     s_ext;
    logic [X_W-1:0]     f_ext;
    logic [X_W-1:0]     ax;
    logic [BOUND_W-1:0] ad;
    logic               same_sign;
    logic [PPR_W-1:0]   ppr_eff;
    logic [CNT_W-1:0]   ac_eff;
    logic [ROT_W-1:0]   freq6;
    logic [ROT5_W-1:0]  rotor5;

    div_req_t           div_req;
    unit_stat_t         div_stat;
    logic [DIV_W-1:0]   div_dividend;
    logic [DIV_W-1:0]   div_divisor;
    logic [DIV_W-1:0]   div_q;
    logic               mul_start;
    logic [DIV_W-1:0]   mul_mcand;
    logic [MUL_B_W-1:0] mul_mplier;
    unit_stat_t         mul_stat;
    logic [DIV_W-1:0]   mul_prod;

    tach_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .stat     (div_stat),
        .quotient (div_q)
    );

    tach_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .mcand   (mul_mcand),
        .mplier  (mul_mplier),
        .stat    (mul_stat),
        .product (mul_prod)
    );

    // Timing of the incoming request
    assign time_ext = DIV_W'(time_us);
    assign now      = time_ext[TW-1:0];
    assign iv       = now - last_reg;
    assign sum_add  = {1'b0, sum_reg} + {1'b0, iv};
    assign sum_sat  = sum_add[TW] ? '1 : sum_add[TW-1:0];
    assign idle     = (now < last_reg) ? '0 : (now - last_reg);
    assign lower    = hon_reg ? TMO_W'(hys_reg) : '0;
    assign thr      = (tmo_reg > lower) ? (tmo_reg - lower) : '0;
    assign stop_now = (DIV_W'(piv_reg) > DIV_W'(thr)) || (DIV_W'(idle) > DIV_W'(thr));

    // Averaging count map operands
    assign top       = (maxc_reg == '0) ? CNT_W'(1) : maxc_reg;
    assign top_m1    = top - 1'b1;
    assign iv_wide   = DIV_W'(piv_reg);
    assign x         = (iv_wide > X_CAP) ? X_CAP[X_W-1:0] : iv_wide[X_W-1:0];
    assign s_ext     = X_W'(slow_reg);
    assign f_ext     = X_W'(fast_reg);
    assign ax        = (x > s_ext) ? (x - s_ext) : (s_ext - x);
    assign ad        = (fast_reg > slow_reg) ? (fast_reg - slow_reg) : (slow_reg - fast_reg);
    assign same_sign = ((x > s_ext) && (fast_reg > slow_reg))
                    || ((x < s_ext) && (fast_reg < slow_reg));

    assign ppr_eff = (ppr_reg == '0) ? PPR_W'(1) : ppr_reg;
    assign ac_eff  = (ac_reg == '0) ? CNT_W'(1) : ac_reg;
    assign freq6   = {1'b0, freq_reg, 2'b00} + {2'b00, freq_reg, 1'b0};
    assign rotor5  = {1'b0, rotor_reg, 2'b00} + {3'b000, rotor_reg};

    // Operand selection for the shared units
    always_comb
    begin
        div_dividend  = '0;
        div_divisor   = '0;
        div_req.len   = '0;
        div_req.start = go_reg && ((state_reg == ST_AVG) || (state_reg == ST_PDIV)
                        || (state_reg == ST_FREQ) || (state_reg == ST_ROT)
                        || (state_reg == ST_RPM) || (state_reg == ST_WHL)
                        || (state_reg == ST_WRPM));
        mul_mcand     = '0;
        mul_mplier    = '0;
        case (state_reg)
            ST_AVG:
            begin
                div_dividend = DIV_W'(sum_reg) << (DIV_W - TW);
                div_divisor  = DIV_W'(ac_eff);
                div_req.len  = DIV_CNT_W'(TW);
            end
            ST_PMUL:
            begin
                mul_mcand  = DIV_W'(ax);
                mul_mplier = MUL_B_W'(top_m1);
            end
            ST_PDIV:
            begin
                div_dividend = mul_prod << (DIV_W - PICK_BITS);
                div_divisor  = DIV_W'(ad);
                div_req.len  = DIV_CNT_W'(PICK_BITS);
            end
            ST_FREQ:
            begin
                div_dividend = DIV_W'(FREQ_NUMERATOR) << (DIV_W - FREQ_BITS);
                div_divisor  = DIV_W'(avg_reg);
                div_req.len  = DIV_CNT_W'(FREQ_BITS);
            end
            ST_ROT:
            begin
                div_dividend = DIV_W'(freq6) << (DIV_W - ROT_W);
                div_divisor  = DIV_W'(ppr_eff);
                div_req.len  = DIV_CNT_W'(ROT_W);
            end
            ST_RPM:
            begin
                div_dividend = DIV_W'(rotor_reg) << (DIV_W - ROT_W);
                div_divisor  = RPM_DIVISOR;
                div_req.len  = DIV_CNT_W'(ROT_W);
            end
            ST_WHL:
            begin
                div_dividend = DIV_W'(rotor5) << (DIV_W - ROT5_W);
                div_divisor  = WHEEL_DIVISOR;
                div_req.len  = DIV_CNT_W'(ROT5_W);
            end
            ST_WRPM:
            begin
                div_dividend = DIV_W'(wheel_reg) << (DIV_W - WHL_W);
                div_divisor  = RPM_DIVISOR;
                div_req.len  = DIV_CNT_W'(WHL_W);
            end
            ST_SPD:
            begin
                mul_mcand  = DIV_W'(wheel_reg);
                mul_mplier = SPEED_FACTOR;
            end
            default:
            begin
                div_dividend = '0;
            end
        endcase
    end

    assign mul_start = go_reg && ((state_reg == ST_PMUL) || (state_reg == ST_SPD));

    assign in_ready = (state_reg == ST_IDLE);

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        go_next        = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        out_load       = 1'b0;
        last_next      = last_reg;
        piv_next       = piv_reg;
        avg_next       = avg_reg;
        sum_next       = sum_reg;
        ac_next        = ac_reg;
        pig_next       = pig_reg;
        hon_next       = hon_reg;
        stop_next      = stop_reg;
        liv_next       = liv_reg;
        freq_next      = freq_reg;
        rotor_next     = rotor_reg;
        rpm_next       = rpm_reg;
        wheel_next     = wheel_reg;
        wrpm_next      = wrpm_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (operation == OP_EDGE)
                    begin
                        piv_next  = iv;
                        last_next = now;
                        if (pig_reg >= ac_reg)
                        begin
                            pig_next   = CNT_W'(1);
                            state_next = ST_AVG;
                            go_next    = 1'b1;
                        end
                        else
                        begin
                            pig_next = pig_reg + 1'b1;
                            sum_next = sum_sat;
                        end
                    end
                    else
                    begin
                        stop_next  = stop_now;
                        hon_next   = stop_now;
                        liv_next   = sat32(DIV_W'(piv_reg));
                        state_next = ST_FREQ;
                        go_next    = 1'b1;
                    end
                end
            end
            ST_AVG:
            begin
                if (div_stat.done)
                begin
                    avg_next   = div_q[TW-1:0];
                    sum_next   = piv_reg;
                    state_next = ST_IDLE;
                    if (slow_reg == fast_reg)
                    begin
                        ac_next = (x <= f_ext) ? top : CNT_W'(1);
                    end
                    else if (!same_sign || (top == CNT_W'(1)))
                    begin
                        ac_next = CNT_W'(1);
                    end
                    else
                    begin
                        state_next = ST_PMUL;
                        go_next    = 1'b1;
                    end
                end
            end
            ST_PMUL:
            begin
                if (mul_stat.done)
                begin
                    state_next = ST_PDIV;
                    go_next    = 1'b1;
                end
            end
            ST_PDIV:
            begin
                if (div_stat.done)
                begin
                    ac_next    = (div_q >= DIV_W'(top_m1)) ? top : (div_q[CNT_W-1:0] + 1'b1);
                    state_next = ST_IDLE;
                end
            end
            ST_FREQ:
            begin
                if (div_stat.done)
                begin
                    freq_next  = (stop_reg || (avg_reg == '0)) ? '0 : sat32(div_q);
                    state_next = ST_ROT;
                    go_next    = 1'b1;
                end
            end
            ST_ROT:
            begin
                if (div_stat.done)
                begin
                    rotor_next = div_q[ROT_W-1:0];
                    state_next = ST_RPM;
                    go_next    = 1'b1;
                end
            end
            ST_RPM:
            begin
                if (div_stat.done)
                begin
                    rpm_next   = sat32(div_q);
                    state_next = ST_WHL;
                    go_next    = 1'b1;
                end
            end
            ST_WHL:
            begin
                if (div_stat.done)
                begin
                    wheel_next = div_q[WHL_W-1:0];
                    state_next = ST_WRPM;
                    go_next    = 1'b1;
                end
            end
            ST_WRPM:
            begin
                if (div_stat.done)
                begin
                    wrpm_next  = sat32(div_q);
                    state_next = ST_SPD;
                    go_next    = 1'b1;
                end
            end
            ST_SPD:
            begin
                if (mul_stat.done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                // hold until the output register frees
                if (!out_valid_reg || out_ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            go_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            last_reg      <= '0;
            piv_reg       <= TW'(INIT_INTERVAL);
            avg_reg       <= TW'(INIT_INTERVAL);
            sum_reg       <= '0;
            ac_reg        <= CNT_W'(1);
            pig_reg       <= CNT_W'(1);
            hon_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            go_reg        <= go_next;
            out_valid_reg <= out_valid_next;
            last_reg      <= last_next;
            piv_reg       <= piv_next;
            avg_reg       <= avg_next;
            sum_reg       <= sum_next;
            ac_reg        <= ac_next;
            pig_reg       <= pig_next;
            hon_reg       <= hon_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ppr_reg  <= PPR_RST;
            tmo_reg  <= TMO_RST;
            hys_reg  <= HYS_RST;
            slow_reg <= SLOW_RST;
            fast_reg <= FAST_RST;
            maxc_reg <= MAXC_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PPR:  ppr_reg  <= cfg_data[PPR_W-1:0];
                CFG_TMO:  tmo_reg  <= cfg_data[TMO_W-1:0];
                CFG_HYS:  hys_reg  <= cfg_data[HYS_W-1:0];
                CFG_SLOW: slow_reg <= cfg_data[BOUND_W-1:0];
                CFG_FAST: fast_reg <= cfg_data[BOUND_W-1:0];
                CFG_MAXC: maxc_reg <= cfg_data[CNT_W-1:0];
                default:  ppr_reg  <= ppr_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        stop_reg  <= stop_next;
        liv_reg   <= liv_next;
        freq_reg  <= freq_next;
        rotor_reg <= rotor_next;
        rpm_reg   <= rpm_next;
        wheel_reg <= wheel_next;
        wrpm_reg  <= wrpm_next;
        if (out_load)
        begin
            o_freq_reg  <= freq_reg;
            o_rotor_reg <= rpm_reg;
            o_wheel_reg <= wrpm_reg;
            o_speed_reg <= sat32(mul_prod >> SPEED_SHIFT);
            o_liv_reg   <= liv_reg;
            o_stop_reg  <= stop_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign pulse_freq_x1e4  = o_freq_reg;
    assign rotor_rpm_x10    = o_rotor_reg;
    assign wheel_rpm_x10    = o_wheel_reg;
    assign wheel_speed      = o_speed_reg;
    assign last_interval_us = o_liv_reg;
    assign stopped          = o_stop_reg;

    a_stop_zero_freq: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && stopped) |-> (pulse_freq_x1e4 == '0))
        else $error("stopped result carries a nonzero frequency");

    a_wheel_le_rotor: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (wheel_rpm_x10 <= rotor_rpm_x10))
        else $error("wheel rpm exceeds rotor rpm");

    a_group_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (pig_reg != '0) && (ac_reg != '0) && (pig_reg <= ac_reg))
        else $error("averaging group count out of range");

    a_div_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> !div_stat.busy)
        else $error("divider restarted while busy");

endmodule
